@@ hdl/tea_pkg.sv @@
// Shared types, constants and helpers of the temporal earliest-arrival scan.
// No dependencies; every other file but tea_ram refers to it by scoped names.
package tea_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int VTX_W        = $clog2(MAX_VERTICES);
   localparam int VCNT_W       = 11;
   localparam int TIME_W       = 32;
   localparam int EPOCH_W      = 8;
   localparam int WORD_W       = EPOCH_W + TIME_W;
   localparam int PADDR_W      = 4;
   localparam int PDATA_W      = 32;

   localparam logic [EPOCH_W-1:0] EPOCH_NONE = '1;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST = EPOCH_NONE - EPOCH_W'(1);
   localparam logic [VCNT_W-1:0]  VCNT_RESET = VCNT_W'(1024);

   localparam logic [1:0] REG_NUM_VERTICES  = 2'd0;
   localparam logic [1:0] REG_SOURCE_VERTEX = 2'd1;
   localparam logic [1:0] REG_TARGET_VERTEX = 2'd2;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_RANGE = 2'd1,
      ERR_ORDER = 2'd2
   } err_type;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } clr_state_type;

   typedef struct packed {
      logic [VCNT_W-1:0] num_vertices;
      logic [VTX_W-1:0]  source_vertex;
      logic [VTX_W-1:0]  target_vertex;
   } cfg_type;

   typedef struct packed {
      logic [VTX_W-1:0]   edge_from;
      logic [VTX_W-1:0]   edge_to;
      logic [TIME_W-1:0]  edge_time;
      logic               has_edge;
      logic               first_edge;
      logic               last_edge;
      logic [EPOCH_W-1:0] epoch;
   } item_type;

   typedef struct packed {
      logic              en;
      logic [VTX_W-1:0]  addr;
      logic [WORD_W-1:0] data;
   } wr_type;

   typedef struct packed {
      logic               valid;
      logic [EPOCH_W-1:0] epoch;
      err_type            list_error;
   } query_type;

   typedef struct packed {
      logic              query_found;
      logic [TIME_W-1:0] arrival_time;
      logic [1:0]        error_code;
   } result_type;

   function automatic logic [VCNT_W-1:0] vertex_limit(logic [VCNT_W-1:0] count);
      return (count > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : count;
   endfunction

   function automatic logic in_range(logic [VTX_W-1:0] vtx, logic [VCNT_W-1:0] lim);
      return VCNT_W'(vtx) < lim;
   endfunction

endpackage

@@ hdl/tea_req_if.sv @@
// Edge channel: valid/ready handshake with one temporal edge per transfer.
// Depends on tea_pkg for field widths.
interface tea_req_if;
   logic                        valid;
   logic                        ready;
   logic [tea_pkg::VTX_W-1:0]   edge_from;
   logic [tea_pkg::VTX_W-1:0]   edge_to;
   logic [tea_pkg::TIME_W-1:0]  edge_time;
   logic                        has_edge;
   logic                        first_edge;
   logic                        last_edge;

   modport source (output valid, edge_from, edge_to, edge_time, has_edge, first_edge,
                   last_edge, input ready);
   modport sink (input valid, edge_from, edge_to, edge_time, has_edge, first_edge,
                 last_edge, output ready);
endinterface

@@ hdl/tea_rsp_if.sv @@
// Result channel: valid/ready handshake with one query result per transfer.
// Depends on tea_pkg for field widths.
interface tea_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        query_found;
   logic [tea_pkg::TIME_W-1:0]  arrival_time;
   logic [1:0]                  error_code;

   modport source (output valid, query_found, arrival_time, error_code, input ready);
   modport sink (input valid, query_found, arrival_time, error_code, output ready);
endinterface

@@ hdl/tea_ram.sv @@
// Generic RAM: one write port, two read ports, registered read data (read-old).
// No dependencies.
module tea_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 40,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_a_addr,
   output logic [WIDTH-1:0] rd_a_data,
   input  logic [AW-1:0]    rd_b_addr,
   output logic [WIDTH-1:0] rd_b_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

@@ hdl/tea_csr.sv @@
// APB-style register file: vertex count, source and target vertex.
// Depends on tea_pkg.
module tea_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tea_pkg::PADDR_W-1:0]   paddr,
   input  logic [tea_pkg::PDATA_W-1:0]   pwdata,
   output logic [tea_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready,
   output tea_pkg::cfg_type              cfg
);

   logic [tea_pkg::VCNT_W-1:0] vcount_ff;
   logic [tea_pkg::VTX_W-1:0]  source_ff;
   logic [tea_pkg::VTX_W-1:0]  target_ff;
   logic [1:0]                 reg_idx;
   logic                       wr_en;

   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= tea_pkg::VCNT_RESET;
         source_ff <= '0;
         target_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            tea_pkg::REG_NUM_VERTICES:  vcount_ff <= pwdata[tea_pkg::VCNT_W-1:0];
            tea_pkg::REG_SOURCE_VERTEX: source_ff <= pwdata[tea_pkg::VTX_W-1:0];
            tea_pkg::REG_TARGET_VERTEX: target_ff <= pwdata[tea_pkg::VTX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         tea_pkg::REG_NUM_VERTICES:  prdata = tea_pkg::PDATA_W'(vcount_ff);
         tea_pkg::REG_SOURCE_VERTEX: prdata = tea_pkg::PDATA_W'(source_ff);
         tea_pkg::REG_TARGET_VERTEX: prdata = tea_pkg::PDATA_W'(target_ff);
         default:                    prdata = '0;
      endcase
   end

   assign cfg.num_vertices  = vcount_ff;
   assign cfg.source_vertex = source_ff;
   assign cfg.target_vertex = target_ff;

endmodule

@@ hdl/tea_relax.sv @@
// Relax stage: takes read data for the edge's tail and head, forwards the last
// write, updates order/range error state and writes the head back. Uses tea_pkg.
module tea_relax (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  tea_pkg::item_type             item_in,
   input  tea_pkg::cfg_type              cfg,
   input  logic                          clearing,
   input  logic [tea_pkg::WORD_W-1:0]    rd_from_data,
   input  logic [tea_pkg::WORD_W-1:0]    rd_to_data,
   output tea_pkg::wr_type               mem_wr,
   output tea_pkg::wr_type               fwd,
   output tea_pkg::query_type            query,
   output logic                          busy
);

   logic                        s1_valid_ff;
   tea_pkg::item_type           s1_ff;
   logic [tea_pkg::TIME_W-1:0]  prev_time_ff;
   logic                        have_prev_ff;
   tea_pkg::err_type            list_err_ff;
   tea_pkg::wr_type             fwd_ff;

   logic [tea_pkg::VCNT_W-1:0]  lim;
   logic [tea_pkg::WORD_W-1:0]  from_word;
   logic [tea_pkg::WORD_W-1:0]  to_word;
   logic                        from_valid;
   logic                        to_valid;
   logic [tea_pkg::TIME_W-1:0]  from_time;
   logic [tea_pkg::TIME_W-1:0]  to_time;
   logic [tea_pkg::TIME_W-1:0]  prev_time_in;
   logic                        have_prev_in;
   tea_pkg::err_type            list_err_in;
   logic                        reached;
   logic                        update;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_ff <= item_in;
      end
   end

   assign lim = tea_pkg::vertex_limit(cfg.num_vertices);

   // latest write not yet visible through the registered read
   assign from_word = (fwd_ff.en && fwd_ff.addr == s1_ff.edge_from) ? fwd_ff.data : rd_from_data;
   assign to_word   = (fwd_ff.en && fwd_ff.addr == s1_ff.edge_to) ? fwd_ff.data : rd_to_data;

   assign from_valid = from_word[tea_pkg::WORD_W-1 -: tea_pkg::EPOCH_W] == s1_ff.epoch;
   assign to_valid   = to_word[tea_pkg::WORD_W-1 -: tea_pkg::EPOCH_W] == s1_ff.epoch;
   assign from_time  = from_word[tea_pkg::TIME_W-1:0];
   assign to_time    = to_word[tea_pkg::TIME_W-1:0];

   always_comb begin
      prev_time_in = s1_ff.first_edge ? '0 : prev_time_ff;
      have_prev_in = s1_ff.first_edge ? 1'b0 : have_prev_ff;
      list_err_in  = s1_ff.first_edge ? tea_pkg::ERR_NONE : list_err_ff;
      reached      = 1'b0;
      update       = 1'b0;
      if (s1_ff.has_edge) begin
         if (have_prev_in && s1_ff.edge_time < prev_time_in) begin
            list_err_in = tea_pkg::ERR_ORDER;
         end
         prev_time_in = s1_ff.edge_time;
         have_prev_in = 1'b1;
         if (!tea_pkg::in_range(s1_ff.edge_from, lim) ||
             !tea_pkg::in_range(s1_ff.edge_to, lim)) begin
            if (list_err_in == tea_pkg::ERR_NONE) begin
               list_err_in = tea_pkg::ERR_RANGE;
            end
         end else begin
            reached = (s1_ff.edge_from == cfg.source_vertex) ||
                      (from_valid && from_time < s1_ff.edge_time);
            update  = reached && (!to_valid || s1_ff.edge_time < to_time);
         end
      end
   end

   assign mem_wr.en   = s1_valid_ff && update;
   assign mem_wr.addr = s1_ff.edge_to;
   assign mem_wr.data = {s1_ff.epoch, s1_ff.edge_time};

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= '0;
         have_prev_ff <= 1'b0;
         list_err_ff  <= tea_pkg::ERR_NONE;
         fwd_ff.en    <= 1'b0;
      end else begin
         if (s1_valid_ff) begin
            prev_time_ff <= prev_time_in;
            have_prev_ff <= have_prev_in;
            list_err_ff  <= list_err_in;
         end
         if (clearing) begin
            fwd_ff.en <= 1'b0;
         end else if (mem_wr.en) begin
            fwd_ff.en <= 1'b1;
         end
      end
      if (mem_wr.en) begin
         fwd_ff.addr <= mem_wr.addr;
         fwd_ff.data <= mem_wr.data;
      end
   end

   assign fwd = fwd_ff;

   assign query.valid      = s1_valid_ff && s1_ff.last_edge;
   assign query.epoch      = s1_ff.epoch;
   assign query.list_error = list_err_in;
   assign busy             = s1_valid_ff;

endmodule

@@ hdl/tea_result.sv @@
// Query stage: reads the target entry, forms the result and queues it in a
// two-entry output buffer. Uses tea_pkg and tea_rsp_if.
module tea_result (
   input  logic                          clock,
   input  logic                          reset,
   input  tea_pkg::query_type            query,
   input  tea_pkg::cfg_type              cfg,
   input  logic [tea_pkg::WORD_W-1:0]    rd_data,
   input  tea_pkg::wr_type               fwd,
   tea_rsp_if.source                     rsp_ch,
   output logic                          last_ok
);

   logic                        s2_valid_ff;
   tea_pkg::query_type          s2_ff;
   tea_pkg::result_type         fifo_ff [2];
   logic                        wr_ptr_ff;
   logic                        rd_ptr_ff;
   logic [1:0]                  count_ff;

   logic [tea_pkg::VCNT_W-1:0]  lim;
   logic [tea_pkg::WORD_W-1:0]  tgt_word;
   logic                        tgt_valid;
   tea_pkg::result_type         res;
   logic                        push;
   logic                        pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= query.valid;
      end
      if (query.valid) begin
         s2_ff <= query;
      end
   end

   assign lim       = tea_pkg::vertex_limit(cfg.num_vertices);
   assign tgt_word  = (fwd.en && fwd.addr == cfg.target_vertex) ? fwd.data : rd_data;
   assign tgt_valid = tgt_word[tea_pkg::WORD_W-1 -: tea_pkg::EPOCH_W] == s2_ff.epoch;

   always_comb begin
      res = '0;
      priority if (!tea_pkg::in_range(cfg.source_vertex, lim) ||
                   !tea_pkg::in_range(cfg.target_vertex, lim)) begin
         res.error_code = tea_pkg::ERR_RANGE;
      end else if (cfg.source_vertex == cfg.target_vertex) begin
         res.query_found = 1'b1;
      end else if (s2_ff.list_error != tea_pkg::ERR_NONE) begin
         res.error_code = s2_ff.list_error;
      end else if (tgt_valid) begin
         res.query_found  = 1'b1;
         res.arrival_time = tgt_word[tea_pkg::TIME_W-1:0];
      end else begin
         res = '0;
      end
   end

   assign push = s2_valid_ff;
   assign pop  = rsp_ch.valid && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) begin
         fifo_ff[wr_ptr_ff] <= res;
      end
   end

   assign rsp_ch.valid        = count_ff != 2'd0;
   assign rsp_ch.query_found  = fifo_ff[rd_ptr_ff].query_found;
   assign rsp_ch.arrival_time = fifo_ff[rd_ptr_ff].arrival_time;
   assign rsp_ch.error_code   = fifo_ff[rd_ptr_ff].error_code;

   // room for one more result counting the one already in this stage
   assign last_ok = (count_ff + 2'(s2_valid_ff)) < 2'd2;

endmodule

@@ hdl/temporal_earliest_arrival_scan.sv @@
// Top level of the temporal earliest-arrival scan: arrival memory, epoch
// control, clearing sweep, register port. Uses tea_pkg, both channel
// interfaces, tea_ram, tea_csr, tea_relax and tea_result.
//
// Usage:
//  - req_ch carries one time-stamped edge per transfer; first_edge starts a
//    new list, last_edge asks for the result of the list.
//  - rsp_ch carries one result per list, once the item marked last_edge has
//    gone through the relax stage and the query stage into the output buffer.
//  - One item per cycle while ready is high. The arrival RAM is read at the
//    edge's tail and head on transfer and written back in the next cycle,
//    with the last write forwarded. The cycle after a last item is taken by
//    the target read, so ready is low then.
//  - Each entry carries an 8-bit list tag; a new list just bumps the tag.
//    After reset a clearing sweep writes all 1024 entries, one per cycle,
//    with ready low during the sweep. Once the 255 tags are used up, the
//    next first item waits for the pipeline to empty and for another
//    sweep, and ready stays low until that sweep is done.
//  - When the receiver stalls, up to two results wait in an output buffer;
//    items without last_edge keep flowing, a last item waits for room.
//  - User writes registers (APB-style port) only with no list active; not enforced.
module temporal_earliest_arrival_scan (
   input  logic                          clock,
   input  logic                          reset,
   tea_req_if.sink                       req_ch,
   tea_rsp_if.source                     rsp_ch,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tea_pkg::PADDR_W-1:0]   paddr,
   input  logic [tea_pkg::PDATA_W-1:0]   pwdata,
   output logic [tea_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready
);

   tea_pkg::cfg_type            cfg;
   tea_pkg::clr_state_type      state_ff;
   tea_pkg::clr_state_type      state_in;
   logic [tea_pkg::VTX_W-1:0]   clr_addr_ff;
   logic [tea_pkg::VTX_W-1:0]   clr_addr_in;
   logic [tea_pkg::EPOCH_W-1:0] epoch_ff;
   logic [tea_pkg::EPOCH_W-1:0] epoch_in;
   logic                        fresh_ff;
   logic                        fresh_in;

   logic                        clearing;
   logic                        wrap_req;
   logic                        accept;
   logic                        bump;
   logic                        last_ok;
   logic                        busy;
   tea_pkg::item_type           item;
   tea_pkg::wr_type             relax_wr;
   tea_pkg::wr_type             mem_wr;
   tea_pkg::wr_type             fwd;
   tea_pkg::query_type          query;
   logic [tea_pkg::VTX_W-1:0]   rd_a_addr;
   logic [tea_pkg::WORD_W-1:0]  rd_a_data;
   logic [tea_pkg::WORD_W-1:0]  rd_b_data;

   tea_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign clearing = state_ff == tea_pkg::ST_CLEAR;
   assign bump     = req_ch.first_edge && !fresh_ff;
   assign wrap_req = req_ch.valid && bump && epoch_ff == tea_pkg::EPOCH_LAST;

   assign req_ch.ready = !clearing && !query.valid && !wrap_req &&
                         (!req_ch.last_edge || last_ok);
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tea_pkg::ST_CLEAR;
         clr_addr_ff <= '0;
         epoch_ff    <= '0;
         fresh_ff    <= 1'b1;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         epoch_ff    <= epoch_in;
         fresh_ff    <= fresh_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      epoch_in    = epoch_ff;
      fresh_in    = fresh_ff;
      unique case (state_ff)
         tea_pkg::ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + tea_pkg::VTX_W'(1);
            if (clr_addr_ff == '1) begin
               state_in = tea_pkg::ST_RUN;
               epoch_in = '0;
               fresh_in = 1'b1;
            end
         end
         tea_pkg::ST_RUN: begin
            if (accept) begin
               fresh_in = 1'b0;
               if (bump) begin
                  epoch_in = epoch_ff + tea_pkg::EPOCH_W'(1);
               end
            end else if (wrap_req && !busy) begin
               state_in    = tea_pkg::ST_CLEAR;
               clr_addr_in = '0;
            end
         end
         default: state_in = tea_pkg::ST_CLEAR;
      endcase
   end

   assign item.edge_from  = req_ch.edge_from;
   assign item.edge_to    = req_ch.edge_to;
   assign item.edge_time  = req_ch.edge_time;
   assign item.has_edge   = req_ch.has_edge;
   assign item.first_edge = req_ch.first_edge;
   assign item.last_edge  = req_ch.last_edge;
   assign item.epoch      = bump ? epoch_ff + tea_pkg::EPOCH_W'(1) : epoch_ff;

   always_comb begin
      if (clearing) begin
         mem_wr.en   = 1'b1;
         mem_wr.addr = clr_addr_ff;
         mem_wr.data = {tea_pkg::EPOCH_NONE, tea_pkg::TIME_W'(0)};
      end else begin
         mem_wr = relax_wr;
      end
   end

   assign rd_a_addr = query.valid ? cfg.target_vertex : req_ch.edge_from;

   tea_ram #(
      .DEPTH (tea_pkg::MAX_VERTICES),
      .WIDTH (tea_pkg::WORD_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (mem_wr.en),
      .wr_addr   (mem_wr.addr),
      .wr_data   (mem_wr.data),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_addr (req_ch.edge_to),
      .rd_b_data (rd_b_data)
   );

   tea_relax u_relax (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .item_in      (item),
      .cfg          (cfg),
      .clearing     (clearing),
      .rd_from_data (rd_a_data),
      .rd_to_data   (rd_b_data),
      .mem_wr       (relax_wr),
      .fwd          (fwd),
      .query        (query),
      .busy         (busy)
   );

   tea_result u_result (
      .clock   (clock),
      .reset   (reset),
      .query   (query),
      .cfg     (cfg),
      .rd_data (rd_a_data),
      .fwd     (fwd),
      .rsp_ch  (rsp_ch),
      .last_ok (last_ok)
   );

endmodule

@@ hdl/tea_checker.sv @@
// Port-level checks for the temporal earliest-arrival scan, bound to the top.
// Depends on tea_pkg and the top level's channel ports.
module tea_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_last,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_found,
   input logic [tea_pkg::TIME_W-1:0]    rsp_time,
   input logic [1:0]                    rsp_err
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_found) && $stable(rsp_time) && $stable(rsp_err))
      else $error("result payload changed while stalled");

   a_target_slot: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("transfer taken in the target read cycle");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last, 3))
      else $error("result without a last item three cycles earlier");

endmodule

bind temporal_earliest_arrival_scan tea_checker u_tea_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_last  (req_ch.last_edge),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_found (rsp_ch.query_found),
   .rsp_time  (rsp_ch.arrival_time),
   .rsp_err   (rsp_ch.error_code)
);
